>>> hdl/clipped_circle_ellipse_rasterizer_top_defines.svh
// assertion macros used by the rasterizer drawing engine
`ifndef CLIPPED_CIRCLE_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH
`define CLIPPED_CIRCLE_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication on i_clk, off while i_rst_n is low
`define CCER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, off while i_rst_n is low
`define CCER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ccer_pkg.sv
// shared types and constants of the rasterizer
`default_nettype none
package ccer_pkg;

    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_READ     = 3'd1;
    localparam logic [2:0] MODE_CLEAR    = 3'd2;
    localparam logic [2:0] MODE_CIRCLE   = 3'd3;
    localparam logic [2:0] MODE_ELL_LINE = 3'd4;
    localparam logic [2:0] MODE_ELL_FILL = 3'd5;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    // midpoint circle decision constants
    localparam int CIRC_D0     = 3;
    localparam int CIRC_INC_A  = 6;
    localparam int CIRC_INC_AB = 10;

    localparam int CW = 9;
    localparam int DW = 12;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_dval;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [5:0]  radius_x;
        logic [5:0]  radius_y;
        logic [23:0] paint;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue;

endpackage
`default_nettype wire

>>> hdl/ccer_front.sv
// command intake: drops unused modes and queues the rest for the engine
`default_nettype none
module ccer_front
    import ccer_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [5:0]  i_pos_x,
    input  wire logic [5:0]  i_pos_y,
    input  wire logic [5:0]  i_radius_x,
    input  wire logic [5:0]  i_radius_y,
    input  wire logic [23:0] i_paint,
    input  wire logic        i_clearing,
    output t_queue           o_queue,
    input  wire logic        i_pop
);

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       accept;
    logic       push;

    assign o_stall = i_clearing || (r_count == 2'd2);
    assign accept  = i_valid && !o_stall;
    // modes six and seven do nothing, so they never reach the engine
    assign push    = accept && (i_mode <= MODE_ELL_FILL);

    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.cmd   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop && o_queue.valid) begin
                r_rptr <= !r_rptr;
            end
            case ({push, i_pop && o_queue.valid})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{mode: i_mode, pos_x: i_pos_x, pos_y: i_pos_y,
                             radius_x: i_radius_x, radius_y: i_radius_y, paint: i_paint};
        end
    end

endmodule
`default_nettype wire

>>> hdl/ccer_engine.sv
// drawing engine: pixel sequencer, clip and address stage, frame store, read port
`default_nettype none
`include "clipped_circle_ellipse_rasterizer_top_defines.svh"
module ccer_engine
    import ccer_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_queue      i_queue,
    output logic             o_pop,
    input  wire logic [6:0]  i_width,
    input  wire logic [6:0]  i_height,
    output logic             o_clearing,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_pixel_value
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RPEND = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_CIRC  = 4'd3;
    localparam logic [3:0] S_ESQ   = 4'd4;
    localparam logic [3:0] S_EBND  = 4'd5;
    localparam logic [3:0] S_EEMIT = 4'd6;
    localparam logic [3:0] S_ERSQ  = 4'd7;
    localparam logic [3:0] S_EROWW = 4'd8;
    localparam logic [3:0] S_ETSQ  = 4'd9;
    localparam logic [3:0] S_ETCMP = 4'd10;
    localparam logic [3:0] S_EACC  = 4'd11;

    logic [3:0]  r_state, n_state;
    t_coord      r_cx, n_cx, r_cy, n_cy;
    logic [5:0]  r_ry, n_ry;
    logic [23:0] r_color, n_color;
    logic        r_fill, n_fill;
    t_coord      r_a, n_a, r_b, n_b;
    t_dval       r_d, n_d;
    logic [2:0]  r_oct, n_oct;
    logic [6:0]  r_clx, n_clx, r_cly, n_cly;
    logic [11:0] r_hh, n_hh, r_ww, n_ww, r_rsq, n_rsq;
    logic [23:0] r_bound, n_bound, r_roww, n_roww;
    t_coord      r_span, n_span, r_step, n_step, r_t, n_t, r_k, n_k;
    logic [5:0]  r_row, n_row;
    logic [13:0] r_tsq, n_tsq;
    logic        r_side, n_side, r_center, n_center;
    logic [1:0]  r_quad, n_quad;

    logic        r_p1_vld, n_p1_vld, r_p1_rd, n_p1_rd;
    t_coord      r_p1_x, n_p1_x, r_p1_y, n_p1_y;
    logic [23:0] r_p1_color, n_p1_color;
    logic        r_p2_rd, r_p2_in;
    logic [23:0] r_rd_data;
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        r_sweep;
    logic [AW-1:0] r_sweep_addr;
    logic [23:0] r_frame [DEPTH];

    logic [6:0]  eff_w, eff_h;
    t_coord      oct_x, oct_y;
    t_coord      ell_x, ell_y, row_c;
    logic        ell_last, ell_skip;
    t_coord      circ_a_nx, circ_b_nx, circ_ab;
    logic [26:0] cmp_sum;
    logic        p1_in;
    logic [14:0] p1_lin;
    logic [AW-1:0] p1_addr;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [23:0] mem_wdata;

    always_comb begin
        eff_w = (32'(i_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : i_width;
        eff_h = (32'(i_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : i_height;
    end

    // eight-way symmetric point of the circle
    always_comb begin
        case (r_oct)
            3'd0:    begin oct_x = r_cx + r_a; oct_y = r_cy + r_b; end
            3'd1:    begin oct_x = r_cx - r_a; oct_y = r_cy + r_b; end
            3'd2:    begin oct_x = r_cx + r_a; oct_y = r_cy - r_b; end
            3'd3:    begin oct_x = r_cx - r_a; oct_y = r_cy - r_b; end
            3'd4:    begin oct_x = r_cx + r_b; oct_y = r_cy + r_a; end
            3'd5:    begin oct_x = r_cx + r_b; oct_y = r_cy - r_a; end
            3'd6:    begin oct_x = r_cx - r_b; oct_y = r_cy + r_a; end
            default: begin oct_x = r_cx - r_b; oct_y = r_cy - r_a; end
        endcase
    end

    assign circ_a_nx = r_a + t_coord'(1);
    assign circ_b_nx = r_d[DW-1] ? r_b : r_b - t_coord'(1);
    assign circ_ab   = r_a - r_b;

    // ellipse row emission: full span when filled, the four ends otherwise
    always_comb begin
        row_c    = t_coord'(r_row);
        ell_skip = r_fill && r_span[CW-1];
        if (r_fill) begin
            ell_x    = r_cx + r_k;
            ell_y    = r_side ? r_cy + row_c : r_cy - row_c;
            ell_last = r_side && (r_k == r_span);
        end else begin
            ell_x    = r_quad[0] ? r_cx + r_span : r_cx - r_span;
            ell_y    = r_quad[1] ? r_cy + row_c : r_cy - row_c;
            ell_last = (r_quad == 2'd3);
        end
    end

    assign cmp_sum = 27'(r_tsq * r_hh) + 27'(r_roww);

    always_comb begin
        n_state = r_state;  n_cx = r_cx;     n_cy = r_cy;     n_ry = r_ry;
        n_color = r_color;  n_fill = r_fill; n_a = r_a;       n_b = r_b;
        n_d = r_d;          n_oct = r_oct;   n_clx = r_clx;   n_cly = r_cly;
        n_hh = r_hh;        n_ww = r_ww;     n_rsq = r_rsq;   n_bound = r_bound;
        n_roww = r_roww;    n_span = r_span; n_step = r_step; n_t = r_t;
        n_k = r_k;          n_row = r_row;   n_tsq = r_tsq;   n_side = r_side;
        n_quad = r_quad;    n_center = r_center;
        n_p1_vld = 1'b0;    n_p1_rd = 1'b0;
        n_p1_x = r_p1_x;    n_p1_y = r_p1_y; n_p1_color = r_color;
        o_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!r_sweep && i_queue.valid) begin
                    n_cx    = t_coord'(i_queue.cmd.pos_x);
                    n_cy    = t_coord'(i_queue.cmd.pos_y);
                    n_ry    = i_queue.cmd.radius_y;
                    n_color = i_queue.cmd.paint;
                    n_fill  = (i_queue.cmd.mode == MODE_ELL_FILL);
                    case (i_queue.cmd.mode)
                        MODE_WRITE: begin
                            o_pop      = 1'b1;
                            n_p1_vld   = 1'b1;
                            n_p1_x     = t_coord'(i_queue.cmd.pos_x);
                            n_p1_y     = t_coord'(i_queue.cmd.pos_y);
                            n_p1_color = i_queue.cmd.paint;
                        end
                        MODE_READ: begin
                            if (!r_out_valid) begin
                                o_pop    = 1'b1;
                                n_p1_vld = 1'b1;
                                n_p1_rd  = 1'b1;
                                n_p1_x   = t_coord'(i_queue.cmd.pos_x);
                                n_p1_y   = t_coord'(i_queue.cmd.pos_y);
                                n_state  = S_RPEND;
                            end
                        end
                        MODE_CLEAR: begin
                            o_pop = 1'b1;
                            n_clx = 7'd0;
                            n_cly = 7'd0;
                            if (eff_w != 7'd0 && eff_h != 7'd0) begin
                                n_state = S_CLR;
                            end
                        end
                        MODE_CIRCLE: begin
                            o_pop   = 1'b1;
                            n_a     = t_coord'(0);
                            n_b     = t_coord'(i_queue.cmd.radius_x);
                            n_d     = t_dval'(CIRC_D0) - t_dval'({i_queue.cmd.radius_x, 1'b0});
                            n_oct   = 3'd0;
                            n_state = S_CIRC;
                        end
                        MODE_ELL_LINE, MODE_ELL_FILL: begin
                            o_pop   = 1'b1;
                            n_hh    = 12'(i_queue.cmd.radius_y * i_queue.cmd.radius_y);
                            n_ww    = 12'(i_queue.cmd.radius_x * i_queue.cmd.radius_x);
                            n_span  = t_coord'(i_queue.cmd.radius_x);
                            n_state = S_ESQ;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RPEND: begin
                if (r_p2_rd) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                n_p1_vld = 1'b1;
                n_p1_x   = t_coord'(r_clx);
                n_p1_y   = t_coord'(r_cly);
                if (r_clx == eff_w - 7'd1) begin
                    n_clx = 7'd0;
                    n_cly = r_cly + 7'd1;
                    if (r_cly == eff_h - 7'd1) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clx = r_clx + 7'd1;
                end
            end
            S_CIRC: begin
                n_p1_vld = 1'b1;
                n_p1_x   = oct_x;
                n_p1_y   = oct_y;
                n_oct    = r_oct + 3'd1;
                if (r_oct == 3'd7) begin
                    if (r_d[DW-1]) begin
                        n_d = r_d + t_dval'($signed({r_a, 2'b00})) + t_dval'(CIRC_INC_A);
                    end else begin
                        n_d = r_d + t_dval'($signed({circ_ab, 2'b00})) + t_dval'(CIRC_INC_AB);
                    end
                    n_a = circ_a_nx;
                    n_b = circ_b_nx;
                    if (circ_a_nx > circ_b_nx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ESQ: begin
                n_step   = t_coord'(0);
                n_row    = 6'd0;
                n_center = 1'b1;
                n_state  = S_EBND;
            end
            S_EBND: begin
                n_bound = 24'(r_hh * r_ww);
                n_k     = t_coord'(0) - r_span;
                n_side  = 1'b0;
                n_quad  = 2'd0;
                n_state = S_EEMIT;
            end
            S_EEMIT: begin
                if (!ell_skip) begin
                    n_p1_vld = 1'b1;
                    n_p1_x   = ell_x;
                    n_p1_y   = ell_y;
                end
                if (ell_skip || ell_last) begin
                    if (r_center) begin
                        n_center = 1'b0;
                        n_state  = S_ERSQ;
                    end else if (r_row == r_ry) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 6'd1;
                        n_state = S_ERSQ;
                    end
                end else if (r_fill) begin
                    n_side = !r_side;
                    if (r_side) begin
                        n_k = r_k + t_coord'(1);
                    end
                end else begin
                    n_quad = r_quad + 2'd1;
                end
            end
            S_ERSQ: begin
                n_rsq   = 12'(r_row * r_row);
                n_t     = r_span - r_step + t_coord'(1);
                n_state = S_EROWW;
            end
            S_EROWW: begin
                n_roww  = 24'(r_rsq * r_ww);
                n_state = S_ETSQ;
            end
            S_ETSQ: begin
                if (r_t[CW-1] || r_t == t_coord'(0)) begin
                    n_state = S_EACC;
                end else begin
                    n_tsq   = 14'(r_t[6:0] * r_t[6:0]);
                    n_state = S_ETCMP;
                end
            end
            S_ETCMP: begin
                if (cmp_sum <= 27'(r_bound)) begin
                    n_state = S_EACC;
                end else begin
                    n_t     = r_t - t_coord'(1);
                    n_state = S_ETSQ;
                end
            end
            S_EACC: begin
                n_step  = r_span - r_t;
                n_span  = r_t;
                n_k     = t_coord'(0) - r_t;
                n_side  = 1'b0;
                n_quad  = 2'd0;
                n_state = S_EEMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // clip and linear address of the pixel in the first stage
    always_comb begin
        p1_in = !r_p1_x[CW-1] && !r_p1_y[CW-1]
             && (r_p1_x[CW-2:0] < {1'b0, eff_w})
             && (r_p1_y[CW-2:0] < {1'b0, eff_h});
        p1_lin  = 15'(r_p1_y[6:0] * eff_w) + 15'(r_p1_x[6:0]);
        p1_addr = AW'(p1_lin);
    end

    always_comb begin
        if (r_sweep) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep_addr;
            mem_wdata = 24'd0;
        end else begin
            mem_we    = r_p1_vld && !r_p1_rd && p1_in;
            mem_waddr = p1_addr;
            mem_wdata = r_p1_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[mem_waddr] <= mem_wdata;
        end
        if (r_p1_vld && r_p1_rd) begin
            r_rd_data <= r_frame[p1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_p1_vld     <= 1'b0;
            r_p1_rd      <= 1'b0;
            r_p2_rd      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= n_p1_vld;
            r_p1_rd  <= n_p1_rd;
            r_p2_rd  <= r_p1_vld && r_p1_rd;
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(DEPTH - 1)) begin
                    r_sweep <= 1'b0;
                end
            end
            if (r_p2_rd) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_cx;         r_cy <= n_cy;       r_ry <= n_ry;
        r_color <= n_color;   r_fill <= n_fill;   r_a <= n_a;
        r_b <= n_b;           r_d <= n_d;         r_oct <= n_oct;
        r_clx <= n_clx;       r_cly <= n_cly;     r_hh <= n_hh;
        r_ww <= n_ww;         r_rsq <= n_rsq;     r_bound <= n_bound;
        r_roww <= n_roww;     r_span <= n_span;   r_step <= n_step;
        r_t <= n_t;           r_k <= n_k;         r_row <= n_row;
        r_tsq <= n_tsq;       r_side <= n_side;   r_quad <= n_quad;
        r_center <= n_center;
        r_p1_x <= n_p1_x;     r_p1_y <= n_p1_y;   r_p1_color <= n_p1_color;
        r_p2_in <= p1_in;
        if (r_p2_rd) begin
            r_out_data <= r_p2_in ? r_rd_data : 24'd0;
        end
    end

    assign o_clearing    = r_sweep;
    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_data;

    `CCER_ASSERT_NOW(a_read_slot_free, r_p1_vld && r_p1_rd, !r_out_valid && !r_p2_rd, "read issued into a busy result slot")
    `CCER_ASSERT_NOW(a_sweep_quiet, r_sweep, !r_p1_vld && r_state == S_IDLE, "pixel traffic during the clearing pass")
    `CCER_ASSERT_NEXT(a_read_returns, r_p2_rd, r_out_valid && r_state == S_IDLE, "read data did not reach the output")

endmodule
`default_nettype wire

>>> hdl/clipped_circle_ellipse_rasterizer_top.sv
// top level: config registers, command queue and drawing engine
// read: result registered valid after the first stage and read stage; one read at a time
// write: one per cycle while o_stall is low, written from the first pixel stage
// clear, shapes: one pixel per cycle; ellipse rows test candidates in S_ETSQ, S_ETCMP
// reset: a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT (4096) frame store entries
// during it commands stall but config writes go through; config regs reset to 64 x 64
`default_nettype none
module clipped_circle_ellipse_rasterizer_top
    import ccer_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [5:0]  i_pos_x,
    input  wire logic [5:0]  i_pos_y,
    input  wire logic [5:0]  i_radius_x,
    input  wire logic [5:0]  i_radius_y,
    input  wire logic [23:0] i_paint,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_pixel_value
);

    logic [6:0] r_width;
    logic [6:0] r_height;
    t_queue     queue;
    logic       pop;
    logic       clearing;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[6:0];
                REG_HEIGHT: r_height <= pwdata[6:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, r_height} : {25'd0, r_width};

    ccer_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .i_paint    (i_paint),
        .i_clearing (clearing),
        .o_queue    (queue),
        .i_pop      (pop)
    );

    ccer_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue       (queue),
        .o_pop         (pop),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value)
    );

endmodule
`default_nettype wire
